@@ design/lae_pkg.sv @@
// Shared definitions for the life automaton engine: command and register codes,
// controller states and the fixed field widths of the ports.
// No dependencies.
`default_nettype none

package lae_pkg;

   // Fixed field widths of the ports.
   localparam int CMD_W       = 2;
   localparam int COORD_W     = 6;
   localparam int GRID_SIZE_W = 7;
   localparam int GENS_W      = 16;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 16;

   // Commands.
   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RUN   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_GRID_SIZE   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GENERATIONS = 1'd1;

   // Reset values of the configuration registers.
   localparam logic [GRID_SIZE_W-1:0] GRID_SIZE_RESET   = 7'd64;
   localparam logic [GENS_W-1:0]      GENERATIONS_RESET = 16'd1;

   // B3/S23 rule: neighbor count that gives birth, and the extra count that survives.
   localparam int NB_CNT_W = 4;
   localparam logic [NB_CNT_W-1:0] BIRTH_COUNT   = 4'd3;
   localparam logic [NB_CNT_W-1:0] SURVIVE_COUNT = 4'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WR_MOD,
      ST_RD_DATA,
      ST_RUN_PRIME,
      ST_RUN_FETCH,
      ST_RUN_CALC,
      ST_FINISH
   } lae_state_type;

endpackage

`default_nettype wire

@@ design/lae_row_ram.sv @@
// One grid store: a row-wide synchronous memory, one write port and one read
// port, read data registered. Depends on nothing.
`default_nettype none

module lae_row_ram #(
   parameter int WIDTH  = 64,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ design/lae_row_calc.sv @@
// Next-generation logic for one grid row: one lane per column applies the
// B3/S23 rule to a three-row window. Depends on lae_pkg.
`default_nettype none

module lae_row_calc
   import lae_pkg::*;
#(
   parameter int WIDTH = 64
) (
   input  wire logic [WIDTH-1:0] above,
   input  wire logic [WIDTH-1:0] center,
   input  wire logic [WIDTH-1:0] below,
   input  wire logic [WIDTH-1:0] col_mask,
   output logic      [WIDTH-1:0] next_row
);

   // Padding with a dead column on each side keeps the edge lanes uniform.
   logic [WIDTH+1:0] above_p;
   logic [WIDTH+1:0] center_p;
   logic [WIDTH+1:0] below_p;

   assign above_p  = {1'b0, above, 1'b0};
   assign center_p = {1'b0, center, 1'b0};
   assign below_p  = {1'b0, below, 1'b0};

   for (genvar c = 0; c < WIDTH; c++) begin : g_lane
      logic [NB_CNT_W-1:0] cnt;

      assign cnt = NB_CNT_W'(above_p[c])  + NB_CNT_W'(above_p[c+1]) + NB_CNT_W'(above_p[c+2])
                 + NB_CNT_W'(center_p[c]) + NB_CNT_W'(center_p[c+2])
                 + NB_CNT_W'(below_p[c])  + NB_CNT_W'(below_p[c+1]) + NB_CNT_W'(below_p[c+2]);

      assign next_row[c] = col_mask[c]
                         & ((cnt == BIRTH_COUNT) | (center[c] & (cnt == SURVIVE_COUNT)));
   end

endmodule

`default_nettype wire

@@ design/life_automaton_engine.sv @@
// Top level of the life automaton engine: command controller, configuration
// registers and the two ping-pong grid stores. Depends on lae_pkg, lae_row_ram
// and lae_row_calc.
//
//   channel   ports                                       direction  purpose
//   req       req_valid/req_ready, cmd, row, col, alive_in   in      one command item
//   rsp       rsp_valid/rsp_ready, alive_out, run_done       out     one result per command
//   csr       csr_valid/csr_ready, csr_index, csr_wdata      in      register write
//
// Each grid store holds one row of GRID_MAX cells per word, so a whole row is read,
// updated and written back at once. A write or read command goes from acceptance
// to a loaded result in these steps: accept and row read, row access, result.
// A run command of G generations on an N by N grid goes, per generation, through a
// prime state that reads the first source row, then a fetch state and a compute
// and write-back state for every row, bound by the single read port of each store.
// A run stops early once the grid has period one or two. Reset clears the
// controller, the store select and the response valid, and loads the configuration
// registers with their reset values; the grid contents are undefined until written,
// and there is no clearing pass. Both ready outputs stay low while reset is high.
// A new item is accepted only when the controller is idle; a result waiting on
// rsp_ready stalls only the last step of the next command.
`default_nettype none

module life_automaton_engine
   import lae_pkg::*;
#(
   parameter int GRID_MAX = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [CMD_W-1:0]      req_cmd,
   input  wire logic [COORD_W-1:0]    req_row,
   input  wire logic [COORD_W-1:0]    req_col,
   input  wire logic                  req_alive_in,

   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic                       rsp_alive_out,
   output logic                       rsp_run_done,

   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   // Row and column indexes need IDX_W bits; sizes up to GRID_MAX need CNT_W bits.
   // Size comparisons run at SZ_W bits, wide enough for both the register and GRID_MAX.
   localparam int IDX_W = (GRID_MAX > 1) ? $clog2(GRID_MAX) : 1;
   localparam int CNT_W = $clog2(GRID_MAX + 1);
   localparam int SZ_W  = (CNT_W > GRID_SIZE_W) ? CNT_W : GRID_SIZE_W;

   // ------------------------------------------------------------------
   // Configuration registers. Writes are taken whenever reset is low.
   // ------------------------------------------------------------------
   logic [GRID_SIZE_W-1:0] grid_size_ff, grid_size_in;
   logic [GENS_W-1:0]      generations_ff, generations_in;

   assign csr_ready = ~reset;

   always_comb begin
      grid_size_in   = grid_size_ff;
      generations_in = generations_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_GRID_SIZE:   grid_size_in   = csr_wdata[GRID_SIZE_W-1:0];
            REG_GENERATIONS: generations_in = csr_wdata[GENS_W-1:0];
            default: begin
               grid_size_in   = grid_size_ff;
               generations_in = generations_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_size_ff   <= GRID_SIZE_RESET;
         generations_ff <= GENERATIONS_RESET;
      end else begin
         grid_size_ff   <= grid_size_in;
         generations_ff <= generations_in;
      end
   end

   // Effective grid side: a register value above GRID_MAX acts as GRID_MAX.
   logic [SZ_W-1:0]     grid_ext;
   logic [SZ_W-1:0]     n_eff;
   logic [GRID_MAX-1:0] col_mask;

   assign grid_ext = SZ_W'(grid_size_ff);
   assign n_eff    = (grid_ext > SZ_W'(GRID_MAX)) ? SZ_W'(GRID_MAX) : grid_ext;

   always_comb begin
      for (int c = 0; c < GRID_MAX; c++) begin
         col_mask[c] = (SZ_W'(c) < n_eff);
      end
   end

   // ------------------------------------------------------------------
   // Controller and datapath registers.
   // ------------------------------------------------------------------
   lae_state_type state_ff, state_in;

   logic               cur_is_b_ff, cur_is_b_in;     // store that holds the current grid
   logic [IDX_W-1:0]   row_idx_ff, row_idx_in;       // latched command address
   logic [IDX_W-1:0]   col_idx_ff, col_idx_in;
   logic               alive_ff, alive_in;
   logic               in_range_ff, in_range_in;
   logic [IDX_W-1:0]   r_ff, r_in;                   // row being computed in a run
   logic [GENS_W-1:0]  t_ff, t_in;                   // generation index in a run
   logic               same_ff, same_in;             // destination unchanged so far
   logic [GRID_MAX-1:0] above_ff, above_in;          // masked window rows
   logic [GRID_MAX-1:0] center_ff, center_in;
   logic               res_alive_ff, res_alive_in;   // result waiting for the output slot
   logic               res_done_ff, res_done_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_alive_ff, rsp_alive_in;
   logic               rsp_done_ff, rsp_done_in;

   // Memory ports by role: "cur" is the current grid, "oth" the other store.
   logic                cur_rd_en, oth_rd_en;
   logic [IDX_W-1:0]    cur_rd_addr, oth_rd_addr;
   logic                cur_wr_en, oth_wr_en;
   logic [IDX_W-1:0]    cur_wr_addr, oth_wr_addr;
   logic [GRID_MAX-1:0] cur_wr_data, oth_wr_data;
   logic [GRID_MAX-1:0] cur_rd_data, oth_rd_data;

   // Command decode helpers.
   logic              req_fire;
   logic [SZ_W-1:0]   req_row_ext;
   logic [SZ_W-1:0]   req_col_ext;
   logic              req_in_range;
   logic              slot_free;
   logic [SZ_W-1:0]   r_next_ext;
   logic              below_valid;
   logic              last_row;
   logic [GRID_MAX-1:0] below_now;
   logic [GRID_MAX-1:0] next_row;
   logic              row_same;
   logic [GENS_W-1:0] t_next;
   logic              rem_odd;
   logic [GRID_MAX-1:0] mod_row;

   assign req_ready    = (state_ff == ST_IDLE) & ~reset;
   assign req_fire     = req_valid & req_ready;
   assign req_row_ext  = SZ_W'(req_row);
   assign req_col_ext  = SZ_W'(req_col);
   assign req_in_range = (req_row_ext < n_eff) & (req_col_ext < n_eff);
   assign slot_free    = ~rsp_valid_ff | rsp_ready;

   // Source row r+1 is part of the grid only while r+1 < N; beyond it is dead.
   assign r_next_ext  = SZ_W'(r_ff) + SZ_W'(1);
   assign below_valid = (r_next_ext < n_eff);
   assign last_row    = (r_next_ext == n_eff);
   assign below_now   = below_valid ? (cur_rd_data & col_mask) : '0;
   assign row_same    = ((oth_rd_data & col_mask) == next_row);

   // Generation bookkeeping: when state t+1 equals state t-1 the grid repeats with
   // period two, so the final grid is the new one if the remaining count is even.
   assign t_next  = t_ff + GENS_W'(1);
   assign rem_odd = generations_ff[0] ^ t_ff[0] ^ 1'b1;

   // Single-cell update of the row just read from the current store.
   always_comb begin
      mod_row          = cur_rd_data;
      mod_row[col_idx_ff] = alive_ff;
   end

   lae_row_calc #(
      .WIDTH(GRID_MAX)
   ) u_row_calc (
      .above    (above_ff),
      .center   (center_ff),
      .below    (below_now),
      .col_mask (col_mask),
      .next_row (next_row)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_cmd)
                  CMD_WRITE: state_in = ST_WR_MOD;
                  CMD_READ:  state_in = ST_RD_DATA;
                  CMD_RUN: begin
                     if ((n_eff == '0) || (generations_ff == '0)) begin
                        state_in = ST_FINISH;
                     end else begin
                        state_in = ST_RUN_PRIME;
                     end
                  end
                  default: state_in = ST_FINISH;
               endcase
            end
         end
         ST_WR_MOD:    state_in = ST_FINISH;
         ST_RD_DATA:   state_in = ST_FINISH;
         ST_RUN_PRIME: state_in = ST_RUN_FETCH;
         ST_RUN_FETCH: state_in = ST_RUN_CALC;
         ST_RUN_CALC: begin
            if (!last_row) begin
               state_in = ST_RUN_FETCH;
            end else if ((t_next == generations_ff) || (same_in && (t_ff != '0))) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_RUN_PRIME;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath, memory controls and result.
   always_comb begin
      cur_is_b_in  = cur_is_b_ff;
      row_idx_in   = row_idx_ff;
      col_idx_in   = col_idx_ff;
      alive_in     = alive_ff;
      in_range_in  = in_range_ff;
      r_in         = r_ff;
      t_in         = t_ff;
      same_in      = same_ff;
      above_in     = above_ff;
      center_in    = center_ff;
      res_alive_in = res_alive_ff;
      res_done_in  = res_done_ff;
      rsp_alive_in = rsp_alive_ff;
      rsp_done_in  = rsp_done_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;

      cur_rd_en   = 1'b0;
      cur_rd_addr = row_idx_ff;
      cur_wr_en   = 1'b0;
      cur_wr_addr = row_idx_ff;
      cur_wr_data = mod_row;
      oth_rd_en   = 1'b0;
      oth_rd_addr = r_ff;
      oth_wr_en   = 1'b0;
      oth_wr_addr = r_ff;
      oth_wr_data = (oth_rd_data & ~col_mask) | next_row;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               row_idx_in   = req_row_ext[IDX_W-1:0];
               col_idx_in   = req_col_ext[IDX_W-1:0];
               alive_in     = req_alive_in;
               in_range_in  = req_in_range;
               res_alive_in = 1'b0;
               res_done_in  = (req_cmd == CMD_RUN);
               t_in         = '0;
               // Start the row read now so that the data is there next cycle.
               cur_rd_en    = (req_cmd == CMD_WRITE) || (req_cmd == CMD_READ);
               cur_rd_addr  = req_row_ext[IDX_W-1:0];
            end
         end
         ST_WR_MOD: begin
            cur_wr_en = in_range_ff;
         end
         ST_RD_DATA: begin
            res_alive_in = in_range_ff & cur_rd_data[col_idx_ff];
         end
         ST_RUN_PRIME: begin
            cur_rd_en   = 1'b1;
            cur_rd_addr = '0;
            r_in        = '0;
            same_in     = 1'b1;
            above_in    = '0;
         end
         ST_RUN_FETCH: begin
            // On the first row the primed read of row 0 is on the read port now.
            if (r_ff == '0) begin
               center_in = cur_rd_data & col_mask;
            end
            cur_rd_en   = 1'b1;
            cur_rd_addr = r_ff + IDX_W'(1);
            oth_rd_en   = 1'b1;
            oth_rd_addr = r_ff;
         end
         ST_RUN_CALC: begin
            oth_wr_en = 1'b1;
            same_in   = same_ff & row_same;
            above_in  = center_ff;
            center_in = below_now;
            r_in      = r_ff + IDX_W'(1);
            if (last_row) begin
               t_in = t_next;
               if (t_next == generations_ff) begin
                  cur_is_b_in = ~cur_is_b_ff;
               end else if (same_ff & row_same & (t_ff != '0)) begin
                  cur_is_b_in = ~cur_is_b_ff ^ rem_odd;
               end else begin
                  cur_is_b_in = ~cur_is_b_ff;
               end
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_alive_in = res_alive_ff;
               rsp_done_in  = res_done_ff;
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff & ~rsp_ready;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_is_b_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_is_b_ff  <= cur_is_b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_idx_ff   <= row_idx_in;
      col_idx_ff   <= col_idx_in;
      alive_ff     <= alive_in;
      in_range_ff  <= in_range_in;
      r_ff         <= r_in;
      t_ff         <= t_in;
      same_ff      <= same_in;
      above_ff     <= above_in;
      center_ff    <= center_in;
      res_alive_ff <= res_alive_in;
      res_done_ff  <= res_done_in;
      rsp_alive_ff <= rsp_alive_in;
      rsp_done_ff  <= rsp_done_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_alive_out = rsp_alive_ff;
   assign rsp_run_done  = rsp_done_ff;

   // ------------------------------------------------------------------
   // Grid stores. The select swaps the roles only between generations, never
   // between a read and the use of its data.
   // ------------------------------------------------------------------
   logic                a_wr_en, b_wr_en, a_rd_en, b_rd_en;
   logic [IDX_W-1:0]    a_wr_addr, b_wr_addr, a_rd_addr, b_rd_addr;
   logic [GRID_MAX-1:0] a_wr_data, b_wr_data, a_rd_data, b_rd_data;

   assign a_wr_en   = cur_is_b_ff ? oth_wr_en   : cur_wr_en;
   assign a_wr_addr = cur_is_b_ff ? oth_wr_addr : cur_wr_addr;
   assign a_wr_data = cur_is_b_ff ? oth_wr_data : cur_wr_data;
   assign a_rd_en   = cur_is_b_ff ? oth_rd_en   : cur_rd_en;
   assign a_rd_addr = cur_is_b_ff ? oth_rd_addr : cur_rd_addr;
   assign b_wr_en   = cur_is_b_ff ? cur_wr_en   : oth_wr_en;
   assign b_wr_addr = cur_is_b_ff ? cur_wr_addr : oth_wr_addr;
   assign b_wr_data = cur_is_b_ff ? cur_wr_data : oth_wr_data;
   assign b_rd_en   = cur_is_b_ff ? cur_rd_en   : oth_rd_en;
   assign b_rd_addr = cur_is_b_ff ? cur_rd_addr : oth_rd_addr;

   assign cur_rd_data = cur_is_b_ff ? b_rd_data : a_rd_data;
   assign oth_rd_data = cur_is_b_ff ? a_rd_data : b_rd_data;

   lae_row_ram #(
      .WIDTH  (GRID_MAX),
      .DEPTH  (GRID_MAX),
      .ADDR_W (IDX_W)
   ) u_grid_a (
      .clock   (clock),
      .wr_en   (a_wr_en),
      .wr_addr (a_wr_addr),
      .wr_data (a_wr_data),
      .rd_en   (a_rd_en),
      .rd_addr (a_rd_addr),
      .rd_data (a_rd_data)
   );

   lae_row_ram #(
      .WIDTH  (GRID_MAX),
      .DEPTH  (GRID_MAX),
      .ADDR_W (IDX_W)
   ) u_grid_b (
      .clock   (clock),
      .wr_en   (b_wr_en),
      .wr_addr (b_wr_addr),
      .wr_data (b_wr_data),
      .rd_en   (b_rd_en),
      .rd_addr (b_rd_addr),
      .rd_data (b_rd_data)
   );

endmodule

`default_nettype wire
